FILE: hw/rtl/xeu_pkg.sv
// shared types, constants and entity tables for the xml entity decoder
// no dependencies
package xeu_pkg;

    localparam int NUM_ENT   = 5;
    localparam int BURST_MAX = 6;
    localparam int CNT_W     = 3;

    localparam logic [7:0] AMPERSAND  = 8'h26;
    localparam logic [7:0] SEMICOLON  = 8'h3b;
    localparam logic [7:0] TERMINATOR = 8'h00;

    localparam logic [2:0] ENT_AMP  = 3'd0;
    localparam logic [2:0] ENT_LT   = 3'd1;
    localparam logic [2:0] ENT_GT   = 3'd2;
    localparam logic [2:0] ENT_QUOT = 3'd3;
    localparam logic [2:0] ENT_APOS = 3'd4;

    localparam logic [NUM_ENT-1:0] ALL_CANDIDATES = '1;

    typedef struct packed {
        logic               in_entity;
        logic [NUM_ENT-1:0] candidates;
        logic [2:0]         matched_count;
    } match_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_MAX-1:0]      lasts;
    } burst_t;

    function automatic logic [2:0] ent_len(input logic [2:0] idx);
        logic [2:0] len;
        case (idx)
            ENT_AMP:  len = 3'd4;
            ENT_LT:   len = 3'd3;
            ENT_GT:   len = 3'd3;
            ENT_QUOT: len = 3'd5;
            ENT_APOS: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            ENT_AMP:  c = 8'h26;
            ENT_LT:   c = 8'h3c;
            ENT_GT:   c = 8'h3e;
            ENT_QUOT: c = 8'h22;
            ENT_APOS: c = 8'h27;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ent_name(input logic [2:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            ENT_AMP:
            begin
                case (pos)
                    3'd0:    c = 8'h61;
                    3'd1:    c = 8'h6d;
                    3'd2:    c = 8'h70;
                    3'd3:    c = SEMICOLON;
                    default: c = 8'h00;
                endcase
            end
            ENT_LT:
            begin
                case (pos)
                    3'd0:    c = 8'h6c;
                    3'd1:    c = 8'h74;
                    3'd2:    c = SEMICOLON;
                    default: c = 8'h00;
                endcase
            end
            ENT_GT:
            begin
                case (pos)
                    3'd0:    c = 8'h67;
                    3'd1:    c = 8'h74;
                    3'd2:    c = SEMICOLON;
                    default: c = 8'h00;
                endcase
            end
            ENT_QUOT:
            begin
                case (pos)
                    3'd0:    c = 8'h71;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6f;
                    3'd3:    c = 8'h74;
                    3'd4:    c = SEMICOLON;
                    default: c = 8'h00;
                endcase
            end
            ENT_APOS:
            begin
                case (pos)
                    3'd0:    c = 8'h61;
                    3'd1:    c = 8'h70;
                    3'd2:    c = 8'h6f;
                    3'd3:    c = 8'h73;
                    3'd4:    c = SEMICOLON;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/xeu_if.sv
// valid/ready channel interfaces for escaped input and unescaped output bytes
// no dependencies
interface xeu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xeu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/xeu_decode.sv
// combinational entity matcher: next match state and output burst for one byte
// depends on xeu_pkg
module xeu_decode (
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  xeu_pkg::match_state_t state,
    output xeu_pkg::match_state_t state_next,
    output xeu_pkg::burst_t       burst
);

    logic [xeu_pkg::NUM_ENT-1:0] next_cand;
    logic                        done_hit;
    logic [2:0]                  done_idx;
    logic [2:0]                  mc_inc;
    logic                        fail;
    logic                        consumed;
    logic                        is_amp;
    logic [xeu_pkg::NUM_ENT-1:0] pfx_cand;
    logic [2:0]                  pfx_mc;
    logic [2:0]                  pfx_idx;
    logic                        pfx_any;
    logic [2:0]                  pfx_len;
    logic [2:0]                  len_k;
    logic                        single_vld;
    logic [7:0]                  single_byte;
    logic [3:0]                  single_pos;
    logic [3:0]                  term_pos;

    assign mc_inc = 3'(state.matched_count + 3'd1);
    assign is_amp = (in_byte == xeu_pkg::AMPERSAND);

    always_comb
    begin
        next_cand = '0;
        done_hit  = 1'b0;
        done_idx  = 3'd0;
        for (int i = 0; i < xeu_pkg::NUM_ENT; i++)
        begin
            if (state.candidates[i] &&
                state.matched_count < xeu_pkg::ent_len(3'(i)) &&
                xeu_pkg::ent_name(3'(i), state.matched_count) == in_byte)
            begin
                next_cand[i] = 1'b1;
                if (mc_inc == xeu_pkg::ent_len(3'(i)))
                begin
                    done_hit = 1'b1;
                    done_idx = 3'(i);
                end
            end
        end
    end

    assign fail     = state.in_entity && !done_hit && (next_cand == '0);
    assign consumed = state.in_entity && (done_hit || next_cand != '0);

    // at most one flush carries letters: a failed match, or a live match ended by last
    always_comb
    begin
        pfx_cand = '0;
        pfx_mc   = 3'd0;
        if (fail)
        begin
            pfx_cand = state.candidates;
            pfx_mc   = state.matched_count;
        end
        else if (in_last && consumed && !done_hit)
        begin
            pfx_cand = next_cand;
            pfx_mc   = mc_inc;
        end
    end

    always_comb
    begin
        pfx_idx = 3'd0;
        pfx_any = 1'b0;
        for (int i = xeu_pkg::NUM_ENT - 1; i >= 0; i--)
        begin
            if (pfx_cand[i])
            begin
                pfx_idx = 3'(i);
                pfx_any = 1'b1;
            end
        end
    end

    assign len_k   = xeu_pkg::ent_len(pfx_idx);
    assign pfx_len = !pfx_any ? 3'd0 : ((pfx_mc < len_k) ? pfx_mc : len_k);

    always_comb
    begin
        single_vld  = 1'b0;
        single_byte = in_byte;
        if (done_hit && state.in_entity)
        begin
            single_vld  = 1'b1;
            single_byte = xeu_pkg::ent_char(done_idx);
        end
        else if (!consumed && !is_amp)
        begin
            single_vld = 1'b1;
        end
    end

    assign single_pos = {1'b0, pfx_len};
    assign term_pos   = 4'(single_pos + {3'd0, single_vld});

    always_comb
    begin
        burst.bytes = '0;
        burst.lasts = '0;
        for (int p = 0; p < xeu_pkg::BURST_MAX; p++)
        begin
            if (4'(p) < single_pos)
            begin
                burst.bytes[p] = xeu_pkg::ent_name(pfx_idx, 3'(p));
            end
            else if (single_vld && 4'(p) == single_pos)
            begin
                burst.bytes[p] = single_byte;
            end
            else if (in_last && 4'(p) == term_pos)
            begin
                burst.bytes[p] = xeu_pkg::TERMINATOR;
                burst.lasts[p] = 1'b1;
            end
        end
        burst.count = xeu_pkg::CNT_W'(term_pos + {3'd0, in_last});
    end

    always_comb
    begin
        state_next = state;
        if (in_last)
        begin
            state_next = '0;
        end
        else if (state.in_entity && done_hit)
        begin
            state_next = '0;
        end
        else if (consumed)
        begin
            state_next.candidates    = next_cand;
            state_next.matched_count = mc_inc;
        end
        else if (is_amp)
        begin
            state_next.in_entity     = 1'b1;
            state_next.candidates    = xeu_pkg::ALL_CANDIDATES;
            state_next.matched_count = 3'd0;
        end
        else
        begin
            state_next = '0;
        end
    end

endmodule

FILE: hw/rtl/xml_entity_unescape.sv
// top level of the streaming xml predefined entity decoder
// depends on xeu_pkg, xeu_if (xeu_in_if, xeu_out_if) and xeu_decode
//
// Decodes &amp; &lt; &gt; &quot; &apos; in a byte stream, one input byte per cycle while
// the output keeps up. Each accepted byte is decoded in the same cycle into a burst of
// zero to six output bytes held in a result register; the burst drains one byte per cycle
// on the output channel while it is ready. A new input byte is taken whenever the burst
// register is empty or its final byte is being transferred, so plain text and complete
// entities run at one byte per cycle, while a failed match (the matched letters are
// replayed without the ampersand) or an end of string (a zero byte flagged last follows)
// stalls the input until its extra output bytes have drained.
module xml_entity_unescape (
    input  logic            clk,
    input  logic            rst_n,
    xeu_in_if.sink          din,
    xeu_out_if.source       dout
);

    xeu_pkg::match_state_t         state_reg;
    xeu_pkg::match_state_t         state_next;
    xeu_pkg::burst_t               burst_next;
    xeu_pkg::burst_t               burst_reg;
    logic [xeu_pkg::CNT_W-1:0]     pos_reg;
    logic [xeu_pkg::CNT_W-1:0]     pos_inc;
    logic                          in_xfer;
    logic                          out_xfer;

    xeu_decode u_decode (
        .in_byte    (din.in_byte),
        .in_last    (din.in_last),
        .state      (state_reg),
        .state_next (state_next),
        .burst      (burst_next)
    );

    assign pos_inc       = xeu_pkg::CNT_W'(pos_reg + 1'b1);
    assign dout.valid    = (pos_reg < burst_reg.count);
    assign dout.out_byte = burst_reg.bytes[pos_reg];
    assign dout.out_last = burst_reg.lasts[pos_reg];
    assign out_xfer      = dout.valid && dout.ready;
    assign din.ready     = !dout.valid || (dout.ready && pos_inc == burst_reg.count);
    assign in_xfer       = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            burst_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg <= state_next;
                burst_reg <= burst_next;
                pos_reg   <= '0;
            end
            else if (out_xfer)
            begin
                pos_reg <= pos_inc;
            end
        end
    end

endmodule
